// File: design/bfra_pkg.sv
// shared types and codes for the best-fit region allocator
// no dependencies; used by bfra_cell and best_fit_region_allocator_core
package bfra_pkg;

	// scan modes broadcast along the cell row
	typedef enum logic [1:0] {
		MODE_ALLOC,
		MODE_NEXT_PREV,
		MODE_DUP_EMPTY
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN1,
		ST_SCAN2,
		ST_RESULT
	} state_t;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

endpackage

// File: design/bfra_cell.sv
// one free-table slot plus its stage of the search row
// depends on bfra_pkg
module bfra_cell import bfra_pkg::*; #(
	parameter int AW = 40,
	parameter int IW = 6,
	parameter int CELL_IDX = 0,
	localparam int TOK_W = 2 + 2 * IW + 4 * AW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mode_t            mode,
	input  logic [AW-1:0]    key,
	input  logic [TOK_W-1:0] tok_in,
	output logic [TOK_W-1:0] tok_out,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_idx,
	input  logic             wr_valid,
	input  logic [AW-1:0]    wr_start,
	input  logic [AW-1:0]    wr_len,
	input  logic             clr_a_en,
	input  logic [IW-1:0]    clr_a_idx,
	input  logic             clr_b_en,
	input  logic [IW-1:0]    clr_b_idx
);

	typedef struct packed {
		logic          a_hit;
		logic [IW-1:0] a_idx;
		logic [AW-1:0] a_start;
		logic [AW-1:0] a_len;
		logic          b_hit;
		logic [IW-1:0] b_idx;
		logic [AW-1:0] b_start;
		logic [AW-1:0] b_len;
	} tok_t;

	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic          valid_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] len_q;
	tok_t          tin;
	tok_t          tnext;
	tok_t          tok_q;
	logic          wr_hit;

	assign tin     = tok_in;
	assign tok_out = tok_q;
	assign wr_hit  = wr_en && (wr_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_hit) begin
			valid_q <= wr_valid;
		end else if ((clr_a_en && clr_a_idx == MY_IDX) || (clr_b_en && clr_b_idx == MY_IDX)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			start_q <= wr_start;
			len_q   <= wr_len;
		end
		tok_q <= tnext;
	end

	always_comb begin
		tnext = tin;
		case (mode)
			MODE_ALLOC: begin
				// smallest fitting length, lowest start on a tie
				if (valid_q && len_q >= key && (!tin.a_hit || len_q < tin.a_len ||
						(len_q == tin.a_len && start_q < tin.a_start))) begin
					tnext.a_hit   = 1'b1;
					tnext.a_idx   = MY_IDX;
					tnext.a_start = start_q;
					tnext.a_len   = len_q;
				end
			end
			MODE_NEXT_PREV: begin
				if (valid_q && start_q >= key) begin
					if (!tin.a_hit || start_q < tin.a_start) begin
						tnext.a_hit   = 1'b1;
						tnext.a_idx   = MY_IDX;
						tnext.a_start = start_q;
						tnext.a_len   = len_q;
					end
				end else if (valid_q) begin
					if (!tin.b_hit || start_q > tin.b_start) begin
						tnext.b_hit   = 1'b1;
						tnext.b_idx   = MY_IDX;
						tnext.b_start = start_q;
						tnext.b_len   = len_q;
					end
				end
			end
			MODE_DUP_EMPTY: begin
				if (valid_q && start_q == key) begin
					tnext.a_hit = 1'b1;
				end
				if (!valid_q && !tin.b_hit) begin
					tnext.b_hit = 1'b1;
					tnext.b_idx = MY_IDX;
				end
			end
			default: begin
				tnext = tin;
			end
		endcase
	end

endmodule

// File: design/best_fit_region_allocator_core.sv
// top level: request sequencer around a row of free-table cells
// depends on bfra_pkg and bfra_cell
//
// Arena allocator. A transaction is taken when start is high and busy is low; its
// result appears for exactly one cycle with done high and cannot be held off. The
// free table is a row of FREE_SLOTS cells and a search token walks it one cell per
// cycle; an allocate makes one pass along the row and a release makes two, while a
// zero-size transaction skips the search and goes straight to its result. busy
// stays high until the cycle after done.
module best_fit_region_allocator_core import bfra_pkg::*; #(
	parameter int FREE_SLOTS = 64,
	parameter int ADDR_BITS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [39:0] size_bytes,
	input  logic [39:0] region_offset,
	output logic        done,
	output logic [39:0] placed_offset,
	output logic [39:0] arena_bytes,
	output logic        table_full
);

	localparam int AW = ADDR_BITS;
	localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam int TOK_W = 2 + 2 * IW + 4 * AW;
	localparam int RW = (AW > 40) ? AW : 41;
	localparam logic [RW-1:0] GRAN_MASK = RW'(255);
	localparam logic [RW-1:0] SIZE_LIM = RW'({AW{1'b1}}) & ~GRAN_MASK;
	localparam logic [CW-1:0] SCAN_END = CW'(FREE_SLOTS);
	localparam logic [AW:0] ADDR_MAX = {1'b0, {AW{1'b1}}};

	typedef struct packed {
		logic          a_hit;
		logic [IW-1:0] a_idx;
		logic [AW-1:0] a_start;
		logic [AW-1:0] a_len;
		logic          b_hit;
		logic [IW-1:0] b_idx;
		logic [AW-1:0] b_start;
		logic [AW-1:0] b_len;
	} tok_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] top_q, top_d;
	mode_t         mode_q, mode_d;
	logic          kind_q, kind_d;
	logic [AW-1:0] key_q, key_d;
	logic [AW-1:0] sz_q, sz_d;
	logic [AW-1:0] placed_q, placed_d;
	logic          flag_q, flag_d;

	logic          wr_en, wr_valid, clr_a_en, clr_b_en;
	logic [IW-1:0] wr_idx, clr_a_idx, clr_b_idx;
	logic [AW-1:0] wr_start, wr_len;

	logic [TOK_W-1:0] tok_chain [FREE_SLOTS+1];
	tok_t             res;

	logic [RW-1:0] sz_up, sz_rnd;
	logic [AW:0]   sum1, sum2;
	logic [AW-1:0] sz_m1, sz_m2;
	logic          nx_merge, pv_merge;

	assign tok_chain[0] = '0;
	assign res = tok_chain[FREE_SLOTS];

	for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
		bfra_cell #(
			.AW(AW),
			.IW(IW),
			.CELL_IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.mode(mode_q),
			.key(key_q),
			.tok_in(tok_chain[g]),
			.tok_out(tok_chain[g+1]),
			.wr_en(wr_en),
			.wr_idx(wr_idx),
			.wr_valid(wr_valid),
			.wr_start(wr_start),
			.wr_len(wr_len),
			.clr_a_en(clr_a_en),
			.clr_a_idx(clr_a_idx),
			.clr_b_en(clr_b_en),
			.clr_b_idx(clr_b_idx)
		);
	end

	// round up to 256, saturating at the top of the address range
	assign sz_up  = (RW'(size_bytes) + GRAN_MASK) & ~GRAN_MASK;
	assign sz_rnd = (sz_up > SIZE_LIM) ? SIZE_LIM : sz_up;

	// coalescing with the following and preceding free regions
	assign nx_merge = res.a_hit && (({1'b0, key_q} + {1'b0, sz_q}) == {1'b0, res.a_start});
	assign sum1  = {1'b0, sz_q} + {1'b0, res.a_len};
	assign sz_m1 = nx_merge ? ((sum1 > ADDR_MAX) ? {AW{1'b1}} : sum1[AW-1:0]) : sz_q;
	assign pv_merge = res.b_hit && (({1'b0, res.b_start} + {1'b0, res.b_len}) == {1'b0, key_q});
	assign sum2  = {1'b0, sz_m1} + {1'b0, res.b_len};
	assign sz_m2 = pv_merge ? ((sum2 > ADDR_MAX) ? {AW{1'b1}} : sum2[AW-1:0]) : sz_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			top_q   <= '0;
			mode_q  <= MODE_ALLOC;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			top_q   <= top_d;
			mode_q  <= mode_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		key_q    <= key_d;
		sz_q     <= sz_d;
		placed_q <= placed_d;
		flag_q   <= flag_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		top_d     = top_q;
		mode_d    = mode_q;
		kind_d    = kind_q;
		key_d     = key_q;
		sz_d      = sz_q;
		placed_d  = placed_q;
		flag_d    = flag_q;
		wr_en     = 1'b0;
		wr_idx    = res.a_idx;
		wr_valid  = 1'b0;
		wr_start  = res.a_start;
		wr_len    = res.a_len;
		clr_a_en  = 1'b0;
		clr_a_idx = res.a_idx;
		clr_b_en  = 1'b0;
		clr_b_idx = res.b_idx;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_d   = kind;
					sz_d     = AW'(sz_rnd);
					placed_d = '0;
					flag_d   = 1'b0;
					cnt_d    = '0;
					if (kind == KIND_RELEASE) begin
						key_d  = AW'(region_offset);
						mode_d = MODE_NEXT_PREV;
					end else begin
						key_d  = AW'(sz_rnd);
						mode_d = MODE_ALLOC;
					end
					if (sz_rnd == '0) begin
						if (kind == KIND_ALLOC) begin
							placed_d = top_q;
						end
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SCAN1;
					end
				end
			end
			ST_SCAN1: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == SCAN_END) begin
					cnt_d = '0;
					if (kind_q == KIND_ALLOC) begin
						state_d = ST_RESULT;
						if (!res.a_hit) begin
							placed_d = top_q;
							top_d    = top_q + sz_q;
						end else begin
							placed_d = res.a_start;
							wr_en    = 1'b1;
							wr_idx   = res.a_idx;
							// split off the remainder, or retire an exact fit
							wr_valid = (res.a_len > sz_q);
							wr_start = res.a_start + sz_q;
							wr_len   = res.a_len - sz_q;
						end
					end else begin
						clr_a_en = nx_merge;
						clr_b_en = pv_merge;
						key_d    = pv_merge ? res.b_start : key_q;
						sz_d     = sz_m2;
						mode_d   = MODE_DUP_EMPTY;
						state_d  = ST_SCAN2;
					end
				end
			end
			ST_SCAN2: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == SCAN_END) begin
					cnt_d   = '0;
					state_d = ST_RESULT;
					if (res.a_hit || !res.b_hit) begin
						flag_d = 1'b1;
					end else begin
						wr_en    = 1'b1;
						wr_idx   = res.b_idx;
						wr_valid = 1'b1;
						wr_start = key_q;
						wr_len   = sz_q;
					end
				end
			end
			ST_RESULT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_RESULT);
	assign placed_offset = 40'(placed_q);
	assign arena_bytes   = 40'(top_q);
	assign table_full    = flag_q;

endmodule
